// ----- src/lkc_pkg.sv -----
// lkc_pkg: shared constants and types for the lru key cache
// no dependencies; used by lkc_core, lru_key_cache_top, lru_result_check and testbench

package lkc_pkg;

    // default geometry of the store
    localparam int DEPTH_DEF    = 8;
    localparam int KEY_BITS_DEF = 32;

    // capacity register
    localparam int              CAP_BITS  = 4;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

    // width of the reported evicted key
    localparam int OUT_KEY_BITS = 32;

    // result of one access, passed from the core to the output register
    typedef struct packed {
        logic                    hit;
        logic                    evicted;
        logic [OUT_KEY_BITS-1:0] evicted_key;
    } t_result;

endpackage

// ----- src/lkc_core.sv -----
// lkc_core: key store, valid marks, recency ranks and the combinational lookup with registered update
// depends on lkc_pkg

module lkc_core #(
    parameter int DEPTH    = lkc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = lkc_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [lkc_pkg::CAP_BITS-1:0]  i_capacity,
    output lkc_pkg::t_result              o_result
);

    localparam int RANK_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_BITS  = $clog2(DEPTH + 1);
    localparam int CMP_BITS  = (OCC_BITS > lkc_pkg::CAP_BITS) ? OCC_BITS : lkc_pkg::CAP_BITS;
    localparam int EXT_BITS  = KEY_BITS + lkc_pkg::OUT_KEY_BITS;

    // state
    logic [KEY_BITS-1:0]  r_key  [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [RANK_BITS-1:0] r_rank [DEPTH];
    logic [OCC_BITS-1:0]  r_occ;

    logic [DEPTH-1:0]     n_valid;
    logic [RANK_BITS-1:0] n_rank [DEPTH];
    logic [OCC_BITS-1:0]  n_occ;

    logic [DEPTH-1:0]     match;
    logic [DEPTH-1:0]     victim;
    logic [DEPTH-1:0]     kept;
    logic [DEPTH-1:0]     free_slot;
    logic                 hit;
    logic                 need_evict;
    logic                 gone;
    logic [RANK_BITS-1:0] hit_rank;
    logic [RANK_BITS-1:0] lru_rank;
    logic [KEY_BITS-1:0]  victim_key;
    logic [EXT_BITS-1:0]  victim_key_ext;
    logic [CMP_BITS-1:0]  cap_ext;
    logic [CMP_BITS-1:0]  occ_ext;
    logic [CMP_BITS-1:0]  eff_cap;

    // effective capacity: zero reads as one, saturated at the depth
    always_comb begin
        cap_ext = CMP_BITS'(i_capacity);
        occ_ext = CMP_BITS'(r_occ);
        if (cap_ext == '0) begin
            eff_cap = CMP_BITS'(1);
        end else if (cap_ext > CMP_BITS'(DEPTH)) begin
            eff_cap = CMP_BITS'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // parallel tag compare
    always_comb begin
        hit_rank = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_key);
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
        end
        hit = |match;
    end

    // victim selection: the valid entry with the oldest rank
    always_comb begin
        lru_rank   = RANK_BITS'(r_occ - OCC_BITS'(1));
        need_evict = !hit && (occ_ext >= eff_cap) && (r_occ != '0);
        victim_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            victim[i] = need_evict && r_valid[i] && (r_rank[i] == lru_rank);
            if (victim[i]) begin
                victim_key = victim_key | r_key[i];
            end
        end
        gone           = |victim;
        victim_key_ext = EXT_BITS'(victim_key);
    end

    // lowest free slot once the victim is gone
    assign kept      = r_valid & ~victim;
    assign free_slot = ~kept & (kept + DEPTH'(1));

    // next valid marks, ranks and occupancy
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < DEPTH; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (hit) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (match[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_BITS'(1);
                end
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (kept[i]) begin
                    n_rank[i] = r_rank[i] + RANK_BITS'(1);
                end else begin
                    n_rank[i] = '0;
                end
            end
            n_valid = kept | free_slot;
            n_occ   = r_occ - OCC_BITS'(gone) + OCC_BITS'(|free_slot);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_step) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            for (int i = 0; i < DEPTH; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // key store, written only into the slot that takes the new key
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_step && !hit && free_slot[i]) begin
                r_key[i] <= i_key;
            end
        end
    end

    // result of this access
    always_comb begin
        o_result.hit         = hit;
        o_result.evicted     = gone;
        o_result.evicted_key = victim_key_ext[lkc_pkg::OUT_KEY_BITS-1:0];
    end

    // occupancy tracks the number of valid marks
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == OCC_BITS'($countones(r_valid)))
        else $error("occupancy does not match valid marks");

    // at most one victim per access
    a_victim_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(victim))
        else $error("more than one victim selected");

    // a hit leaves occupancy and valid marks alone
    a_hit_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && hit) |=> ($stable(r_occ) && $stable(r_valid)))
        else $error("hit changed occupancy");

    // eviction only with the store at or above capacity
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && gone) |-> (!hit && (occ_ext >= eff_cap)))
        else $error("eviction below capacity");

    // a miss always finds a slot for the new key
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !hit) |-> (free_slot != '0))
        else $error("miss found no free slot");

endmodule

// ----- src/lru_key_cache_top.sv -----
// lru_key_cache_top: fully associative lru key cache with input and result registers
// depends on lkc_pkg and lkc_core
//
// path: an accepted word waits in the input register, its result in the result register
// throughput: one word per cycle unless stalled, set by the tag compare and rank update
// the output register holds a stalled result while a new word waits in the input register
// reset (synchronous, active low): valid marks, ranks and occupancy cleared,
// capacity set to 8; the key store is not cleared

module lru_key_cache_top #(
    parameter int DEPTH    = lkc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = lkc_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [lkc_pkg::CAP_BITS-1:0]      i_cfg_wr_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [KEY_BITS-1:0]               i_key_tag,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic                              o_evicted,
    output logic [lkc_pkg::OUT_KEY_BITS-1:0]  o_evicted_key
);

    logic [lkc_pkg::CAP_BITS-1:0] r_capacity;
    logic                         r_in_valid;
    logic [KEY_BITS-1:0]          r_in_key;
    logic                         r_out_valid;
    lkc_pkg::t_result             r_out;
    lkc_pkg::t_result             n_out;
    logic                         step;
    logic                         in_take;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkc_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // the held word moves on when the result register is free or being emptied
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key <= i_key_tag;
        end
    end

    // lookup and update
    lkc_core #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_key      (r_in_key),
        .i_capacity (r_capacity),
        .o_result   (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out.hit;
    assign o_evicted     = r_out.evicted;
    assign o_evicted_key = r_out.evicted_key;

endmodule

// ----- tb/lru_result_check.sv -----
// lru_result_check: watches both channels of the lru key cache, predicts every result
// from its own copy of the store and compares; depends on lkc_pkg

module lru_result_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [lkc_pkg::CAP_BITS-1:0]         i_cfg_wr_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [lkc_pkg::KEY_BITS_DEF-1:0]     i_key_tag,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_hit,
    input  logic                                 i_evicted,
    input  logic [lkc_pkg::OUT_KEY_BITS-1:0]     i_evicted_key,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_hits,
    output int                                   o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = lkc_pkg::DEPTH_DEF;

    // predicted contents of the store
    logic [lkc_pkg::KEY_BITS_DEF-1:0] line_key [LINES];
    logic                             line_valid [LINES];
    int                               line_age [LINES];
    int                               fill;
    logic [lkc_pkg::CAP_BITS-1:0]     cap_reg;

    lkc_pkg::t_result awaited_results [$];
    int fails = 0;
    int hits = 0;
    int evictions = 0;

    // one access: find the key, refresh or evict and insert
    function automatic lkc_pkg::t_result predict_access(
        input logic [lkc_pkg::KEY_BITS_DEF-1:0] key
    );
        lkc_pkg::t_result res;
        int slot;
        int r;
        int limit;
        logic placed;
        res    = '0;
        slot   = -1;
        placed = 1'b0;
        limit  = int'(cap_reg);
        if (limit == 0) limit = 1;
        if (limit > LINES) limit = LINES;
        for (int i = 0; i < LINES; i++)
            if (line_valid[i] && line_key[i] == key) slot = i;
        if (slot >= 0) begin
            res.hit = 1'b1;
            r = line_age[slot];
            for (int i = 0; i < LINES; i++)
                if (line_valid[i] && line_age[i] < r) line_age[i]++;
            line_age[slot] = 0;
        end else begin
            // full (or over capacity after a lowered setting): drop the oldest line
            if (fill >= limit && fill > 0) begin
                for (int i = 0; i < LINES; i++) begin
                    if (!res.evicted && line_valid[i] && line_age[i] == fill - 1) begin
                        res.evicted     = 1'b1;
                        res.evicted_key = line_key[i];
                        line_valid[i]   = 1'b0;
                        line_age[i]     = 0;
                        fill--;
                    end
                end
            end
            for (int i = 0; i < LINES; i++)
                if (line_valid[i]) line_age[i]++;
            // new key goes into the lowest free line as most recent
            for (int i = 0; i < LINES; i++) begin
                if (!placed && !line_valid[i]) begin
                    line_key[i]   = key;
                    line_valid[i] = 1'b1;
                    line_age[i]   = 0;
                    fill++;
                    placed = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string what, input lkc_pkg::t_result want,
                                input lkc_pkg::t_result got);
        fails++;
        if (fails <= 10)
            $display("%t %s: expected hit=%0b evicted=%0b key=%h,",
                     $realtime, what, want.hit, want.evicted, want.evicted_key,
                     " got hit=%0b evicted=%0b key=%h",
                     got.hit, got.evicted, got.evicted_key);
    endtask

    // sample both channels at every edge
    always @(posedge i_clk) begin : watch
        lkc_pkg::t_result want;
        lkc_pkg::t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_age[i]   = 0;
            end
            fill    = 0;
            cap_reg = lkc_pkg::CAP_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg_wr_en) cap_reg = i_cfg_wr_data;
            // result word leaving the block
            if (i_out_valid && !i_out_stall) begin
                got = '{hit: i_hit, evicted: i_evicted, evicted_key: i_evicted_key};
                if (awaited_results.size() == 0) begin
                    note_failure("result with nothing awaited", '0, got);
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    if (got.hit !== want.hit || got.evicted !== want.evicted
                            || got.evicted_key !== want.evicted_key)
                        note_failure("result mismatch", want, got);
                    if (want.hit) hits++;
                    if (want.evicted) evictions++;
                end
            end
            // key word entering the block
            if (i_in_valid && !i_in_stall)
                awaited_results.insert(awaited_results.size(), predict_access(i_key_tag));
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
        o_hits       <= hits;
        o_evictions  <= evictions;
    end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives key words and capacity settings into lru_key_cache_top and gives the verdict
// depends on lkc_pkg, lru_key_cache_top and lru_result_check

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 325;
    localparam int HOLD_CYCLES   = 80;
    localparam int DIRECT_A_LEN  = 13;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [lkc_pkg::CAP_BITS-1:0]        cfg_wr_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [lkc_pkg::KEY_BITS_DEF-1:0]    key_tag = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                hit;
    logic                                evicted;
    logic [lkc_pkg::OUT_KEY_BITS-1:0]    evicted_key;

    int fail_count;
    int pending;
    int hits;
    int evictions;

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int words_sent   = 0;
    int cap_writes   = 0;

    // capacity per random phase: extremes, zero and an out-of-range value among them
    logic [lkc_pkg::CAP_BITS-1:0] phase_cap [PHASES] = '{4'd1, 4'd8, 4'd4, 4'd15, 4'd2, 4'd0};

    // fill, touch the oldest, evict, re-miss an evicted key, touch the second newest and the oldest
    logic [31:0] direct_a [DIRECT_A_LEN] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
        32'h0000_0000, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
        32'h5555_5555
    };

    lru_key_cache_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_key_tag     (key_tag),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_hit         (hit),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key)
    );

    lru_result_check check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_key_tag     (key_tag),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_hit         (hit),
        .i_evicted     (evicted),
        .i_evicted_key (evicted_key),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_hits        (hits),
        .o_evictions   (evictions)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // offer one key word, with a random gap first, and wait for it to be taken
    task automatic send_key(input logic [31:0] key);
        if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_tag  <= key;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // stop offering and wait until every awaited result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_capacity(input logic [lkc_pkg::CAP_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_writes++;
    endtask

    // stimulus
    initial begin
        logic [31:0] pool [12];
        int          pool_len;
        logic [31:0] key;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset capacity of eight
        foreach (direct_a[i]) send_key(direct_a[i]);
        drain();
        // capacity zero acts as one, and lies below the current fill
        write_capacity(4'd0);
        send_key(32'hCAFE_F00D);
        send_key(32'h0000_0000);
        send_key(32'h1357_9BDF);
        drain();
        // capacity above the store size saturates
        write_capacity(4'd15);
        send_key(32'h2468_ACE0);
        send_key(32'h2468_ACE0);
        drain();

        // random phases: mostly keys from a small pool so hits and evictions mix
        for (int p = 0; p < PHASES; p++) begin
            in_idle_pct  = (p < 2) ? 24 : (p < 4) ? 73 : 0;
            out_idle_pct = (p < 2) ? 73 : (p < 4) ? 24 : 0;
            write_capacity(phase_cap[p]);
            if (p == 0 || p == 4) hold_req++;
            pool_len = $urandom_range(2, 12);
            for (int i = 0; i < pool_len; i++) pool[i] = $urandom();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) < 75)
                    key = pool[$urandom_range(0, pool_len - 1)];
                else
                    key = $urandom();
                send_key(key);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("%0d key words sent over %0d capacity writes: %0d hits, %0d evictions",
                 words_sent, cap_writes, hits, evictions);
        $display("idle mixes 24/73, 73/24 and none, with two long result hold-offs");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
